// ===== design/scator_constant_add_step_core_macros.svh =====
// assertion macros shared by the scator step checker
`ifndef SCATOR_CONSTANT_ADD_STEP_CORE_MACROS_SVH
`define SCATOR_CONSTANT_ADD_STEP_CORE_MACROS_SVH

// same-cycle implication, disabled during reset
`define SCAS_ASSERT_IMP(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("scas check failed");

// next-cycle implication, disabled during reset
`define SCAS_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("scas check failed");

`endif

// ===== design/scas_pkg.sv =====
// shared types, constants and saturating arithmetic for the scator step
package scas_pkg;

  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 20;
  localparam int MAG_BITS  = 43;
  localparam int QBITS     = 32;
  localparam int REM_BITS  = QBITS + FRAC_BITS;

  localparam logic signed [WORD_BITS-1:0] ONE  = WORD_BITS'(64'd1 << FRAC_BITS);
  localparam logic signed [WORD_BITS-1:0] WMAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam logic signed [WORD_BITS-1:0] WMIN = {1'b1, {(WORD_BITS-1){1'b0}}};
  localparam logic [MAG_BITS-1:0] MAG_POS = MAG_BITS'(64'h7FFF_FFFF);
  localparam logic [MAG_BITS-1:0] MAG_NEG = MAG_BITS'(64'h8000_0000);

  // unit latencies in enabled cycles
  localparam int L_DIV = QBITS + 1;
  localparam int L_SQ  = QBITS;

  // pipeline stage indexes
  localparam int S_IN   = 0;
  localparam int S_SQ   = 1;
  localparam int S_CC   = 2;
  localparam int S_REC  = S_CC + L_DIV + 1;
  localparam int S_M12P = S_REC + 1;
  localparam int S_M12  = S_M12P + 1;
  localparam int S_N    = S_M12 + L_DIV + 1;
  localparam int S_NP   = S_N + 1;
  localparam int S_NC   = S_NP + 1;
  localparam int S_GP   = S_NC + 1;
  localparam int S_GC   = S_GP + 1;
  localparam int S_ABS  = S_GC + 1;
  localparam int S_ADD  = S_ABS + 1;
  localparam int S_LP   = S_ADD + 1;
  localparam int S_LS   = S_LP + 1;
  localparam int S_LEN  = S_LS + L_SQ;
  localparam int S_R1   = S_LEN + L_DIV + 1;
  localparam int S_R2   = S_R1 + 1;
  localparam int S_R3   = S_R2 + 1;
  localparam int S_R4   = S_R3 + 1;
  localparam int S_R5   = S_R4 + 1;
  localparam int N_STG  = S_R5 + 1;

  // mode bits
  localparam int M_SWAP = 0;
  localparam int M_ABS  = 1;
  localparam int M_IMAG = 2;
  localparam int M_SIGN = 3;
  localparam int M_ABSY = 4;
  localparam int M_ABSZ = 5;
  localparam int M_DE   = 6;

  typedef enum logic [2:0] {
    REG_MODE, REG_SMALL, REG_GAIN_X, REG_GAIN_Y, REG_GAIN_Z, REG_DE_SCALE, REG_DE_OFFSET
  } reg_idx_t;

  typedef struct packed {
    logic signed [WORD_BITS-1:0] v;
    logic                        f;
  } sat_t;

  typedef struct packed {
    logic signed [WORD_BITS-1:0] z0, z1, z2;
    logic signed [WORD_BITS-1:0] t0, t1, t2;
    logic signed [WORD_BITS-1:0] de;
    logic signed [WORD_BITS-1:0] cc0, cc1, cc2;
    logic signed [WORD_BITS-1:0] n0, n1, n2;
    logic [63:0]                 p0, p1, p2, p3, p4, p5;
    logic                        is_small;
    logic                        flag;
    logic                        de_flag;
  } item_t;

  typedef struct packed {
    logic signed [WORD_BITS-1:0] z0, z1, z2;
    logic signed [WORD_BITS-1:0] de;
    logic                        flag;
  } res_t;

  function automatic sat_t clampw(input logic neg, input logic [MAG_BITS-1:0] mag);
    sat_t r;
    if (!neg) begin
      if (mag > MAG_POS) begin
        r.v = WMAX;
        r.f = 1'b1;
      end else begin
        r.v = mag[WORD_BITS-1:0];
        r.f = 1'b0;
      end
    end else begin
      if (mag > MAG_NEG) begin
        r.v = WMIN;
        r.f = 1'b1;
      end else begin
        r.v = WORD_BITS'(0) - mag[WORD_BITS-1:0];
        r.f = 1'b0;
      end
    end
    return r;
  endfunction

  function automatic logic [WORD_BITS-1:0] magn(input logic signed [WORD_BITS-1:0] a);
    return a[WORD_BITS-1] ? WORD_BITS'(0) - a : a;
  endfunction

  function automatic sat_t sabs(input logic signed [WORD_BITS-1:0] a);
    return clampw(1'b0, MAG_BITS'(magn(a)));
  endfunction

  function automatic sat_t sadd(input logic signed [WORD_BITS-1:0] a,
                                input logic signed [WORD_BITS-1:0] b);
    logic signed [WORD_BITS:0] s;
    sat_t r;
    s = {a[WORD_BITS-1], a} + {b[WORD_BITS-1], b};
    if (s[WORD_BITS] != s[WORD_BITS-1]) begin
      r.v = s[WORD_BITS] ? WMIN : WMAX;
      r.f = 1'b1;
    end else begin
      r.v = s[WORD_BITS-1:0];
      r.f = 1'b0;
    end
    return r;
  endfunction

  function automatic sat_t ssub(input logic signed [WORD_BITS-1:0] a,
                                input logic signed [WORD_BITS-1:0] b);
    logic signed [WORD_BITS:0] s;
    sat_t r;
    s = {a[WORD_BITS-1], a} - {b[WORD_BITS-1], b};
    if (s[WORD_BITS] != s[WORD_BITS-1]) begin
      r.v = s[WORD_BITS] ? WMIN : WMAX;
      r.f = 1'b1;
    end else begin
      r.v = s[WORD_BITS-1:0];
      r.f = 1'b0;
    end
    return r;
  endfunction

  // 32x32 unsigned magnitude product
  function automatic logic [63:0] mul32(input logic [WORD_BITS-1:0] a,
                                        input logic [WORD_BITS-1:0] b);
    return {32'd0, a} * {32'd0, b};
  endfunction

  // drop fraction bits of a magnitude product and saturate
  function automatic sat_t smulfin(input logic neg, input logic [63:0] p);
    return clampw(neg, p[FRAC_BITS+MAG_BITS-1:FRAC_BITS]);
  endfunction

endpackage

// ===== design/scator_constant_add_step_core.sv =====
// scator constant-add step: top level with config registers and pipeline
//
// usage
// - requests enter on in_valid/in_ready with point z, pixel constant c and
//   a distance estimate; results leave on out_valid/out_ready
// - configuration is written over the apb port (pready is tied high);
//   write only while no request is in flight
// - one request per cycle is accepted while the skid register is empty;
//   requests pass three chained levels of 33-stage dividers (reciprocal, the
//   three shared-denominator quotients, the length ratio), two parallel
//   32-stage square root units and the multiply/clamp stages between them
// - the pipeline moves as one block; an output register plus a skid
//   register let it keep taking requests while a result waits, and it
//   holds (nothing lost or repeated) once the skid register is full
// - reset clears valid bits, the output and skid flags and the config
//   registers (gains and estimate scale to 1.0)
// - saturated flags clamps and divisions by zero that feed the result
module scator_constant_add_step_core import scas_pkg::*; (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [4:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic signed [31:0]          in_z_x,
  input  logic signed [31:0]          in_z_y,
  input  logic signed [31:0]          in_z_z,
  input  logic signed [31:0]          in_c_x,
  input  logic signed [31:0]          in_c_y,
  input  logic signed [31:0]          in_c_z,
  input  logic signed [31:0]          de_in,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [31:0]          out_z_x,
  output logic signed [31:0]          out_z_y,
  output logic signed [31:0]          out_z_z,
  output logic signed [31:0]          de_out,
  output logic                        saturated
);

  // configuration registers
  logic [6:0]                  mode;
  logic [30:0]                 small_limit;
  logic signed [WORD_BITS-1:0] gain_x, gain_y, gain_z, de_scale, de_offset;

  logic     wr;
  reg_idx_t ridx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign ridx   = reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= '0;
      small_limit <= '0;
      gain_x      <= ONE;
      gain_y      <= ONE;
      gain_z      <= ONE;
      de_scale    <= ONE;
      de_offset   <= '0;
    end else if (wr) begin
      unique case (ridx)
        REG_MODE:      mode        <= pwdata[6:0];
        REG_SMALL:     small_limit <= pwdata[30:0];
        REG_GAIN_X:    gain_x      <= pwdata;
        REG_GAIN_Y:    gain_y      <= pwdata;
        REG_GAIN_Z:    gain_z      <= pwdata;
        REG_DE_SCALE:  de_scale    <= pwdata;
        REG_DE_OFFSET: de_offset   <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (ridx)
      REG_MODE:      prdata = {25'd0, mode};
      REG_SMALL:     prdata = {1'b0, small_limit};
      REG_GAIN_X:    prdata = gain_x;
      REG_GAIN_Y:    prdata = gain_y;
      REG_GAIN_Z:    prdata = gain_z;
      REG_DE_SCALE:  prdata = de_scale;
      REG_DE_OFFSET: prdata = de_offset;
      default:       prdata = '0;
    endcase
  end

  // pipeline: stage registers and valid bits advance together on en
  item_t             stg [N_STG];
  item_t             nxt [N_STG];
  logic [N_STG-1:0]  vld;
  logic              en;
  logic              skid_valid;

  assign en       = !skid_valid;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[N_STG-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < N_STG; k++) begin
        stg[k] <= nxt[k];
      end
    end
  end

  // reciprocal of the x term
  logic signed [WORD_BITS-1:0] rec_q;
  logic                        rec_sat;

  scas_div u_div_rec (
    .clk (clk),
    .en  (en),
    .num (WORD_BITS'(ONE)),
    .den (magn(stg[S_CC].cc0)),
    .neg (stg[S_CC].cc0[WORD_BITS-1]),
    .q   (rec_q),
    .sat (rec_sat)
  );

  // three quotients over the shared denominator cc0
  logic signed [WORD_BITS-1:0] q12, q2, q1;
  logic                        q12_sat, q2_sat, q1_sat;

  scas_div u_div_12 (
    .clk (clk),
    .en  (en),
    .num (magn(stg[S_M12].n0)),
    .den (magn(stg[S_M12].cc0)),
    .neg (stg[S_M12].n0[WORD_BITS-1] ^ stg[S_M12].cc0[WORD_BITS-1]),
    .q   (q12),
    .sat (q12_sat)
  );

  scas_div u_div_2 (
    .clk (clk),
    .en  (en),
    .num (magn(stg[S_M12].cc2)),
    .den (magn(stg[S_M12].cc0)),
    .neg (stg[S_M12].cc2[WORD_BITS-1] ^ stg[S_M12].cc0[WORD_BITS-1]),
    .q   (q2),
    .sat (q2_sat)
  );

  scas_div u_div_1 (
    .clk (clk),
    .en  (en),
    .num (magn(stg[S_M12].cc1)),
    .den (magn(stg[S_M12].cc0)),
    .neg (stg[S_M12].cc1[WORD_BITS-1] ^ stg[S_M12].cc0[WORD_BITS-1]),
    .q   (q1),
    .sat (q1_sat)
  );

  // vector lengths, new point and old point
  logic [QBITS-1:0] len_new, len_old;

  scas_sqrt u_sqrt_new (
    .clk (clk),
    .en  (en),
    .s   (stg[S_LS].p0),
    .r   (len_new)
  );

  scas_sqrt u_sqrt_old (
    .clk (clk),
    .en  (en),
    .s   (stg[S_LS].p3),
    .r   (len_old)
  );

  // length ratio for the estimate update
  logic signed [WORD_BITS-1:0] ratio;
  logic                        ratio_sat;

  scas_div u_div_ratio (
    .clk (clk),
    .en  (en),
    .num (len_new),
    .den (len_old),
    .neg (1'b0),
    .q   (ratio),
    .sat (ratio_sat)
  );

  for (genvar k = 0; k < N_STG; k++) begin : g_stage
    if (k == S_IN) begin : g_in
      // capture, optional x/z swap of c
      always_comb begin
        nxt[k]    = '0;
        nxt[k].z0 = in_z_x;
        nxt[k].z1 = in_z_y;
        nxt[k].z2 = in_z_z;
        nxt[k].t0 = mode[M_SWAP] ? in_c_z : in_c_x;
        nxt[k].t1 = in_c_y;
        nxt[k].t2 = mode[M_SWAP] ? in_c_x : in_c_z;
        nxt[k].de = de_in;
      end
    end else if (k == S_SQ) begin : g_sq
      always_comb begin
        nxt[k]    = stg[k-1];
        nxt[k].p0 = mul32(magn(stg[k-1].t0), magn(stg[k-1].t0));
        nxt[k].p1 = mul32(magn(stg[k-1].t1), magn(stg[k-1].t1));
        nxt[k].p2 = mul32(magn(stg[k-1].t2), magn(stg[k-1].t2));
      end
    end else if (k == S_CC) begin : g_cc
      // squares or absolute values, small test on the x term
      always_comb begin
        sat_t a, b, c;
        nxt[k] = stg[k-1];
        if (mode[M_ABS]) begin
          a = sabs(stg[k-1].t0);
          b = sabs(stg[k-1].t1);
          c = sabs(stg[k-1].t2);
        end else begin
          a = smulfin(1'b0, stg[k-1].p0);
          b = smulfin(1'b0, stg[k-1].p1);
          c = smulfin(1'b0, stg[k-1].p2);
        end
        nxt[k].cc0      = a.v;
        nxt[k].cc1      = b.v;
        nxt[k].cc2      = c.v;
        nxt[k].is_small = a.v < $signed({1'b0, small_limit});
        nxt[k].flag     = stg[k-1].flag | a.f | b.f | c.f;
      end
    end else if (k == S_REC) begin : g_rec
      // small x term becomes 1/x - 1
      always_comb begin
        sat_t a;
        nxt[k] = stg[k-1];
        a = ssub(rec_q, ONE);
        if (stg[k-1].is_small) begin
          nxt[k].cc0  = a.v;
          nxt[k].flag = stg[k-1].flag | rec_sat | a.f;
        end
      end
    end else if (k == S_M12P) begin : g_m12p
      always_comb begin
        nxt[k]    = stg[k-1];
        nxt[k].p0 = mul32(magn(stg[k-1].cc1), magn(stg[k-1].cc2));
      end
    end else if (k == S_M12) begin : g_m12
      always_comb begin
        sat_t a;
        nxt[k]      = stg[k-1];
        a           = smulfin(stg[k-1].cc1[WORD_BITS-1] ^ stg[k-1].cc2[WORD_BITS-1],
                              stg[k-1].p0);
        nxt[k].n0   = a.v;
        nxt[k].flag = stg[k-1].flag | a.f;
      end
    end else if (k == S_N) begin : g_n
      // scator sum, real or imaginary variant
      always_comb begin
        sat_t a, b, c;
        nxt[k] = stg[k-1];
        a      = sadd(stg[k-1].t0, q12);
        if (mode[M_IMAG]) begin
          b = ssub(ONE, q2);
          c = ssub(ONE, q1);
        end else begin
          b = sadd(ONE, q2);
          c = sadd(ONE, q1);
        end
        nxt[k].n0   = a.v;
        nxt[k].n1   = b.v;
        nxt[k].n2   = c.v;
        nxt[k].flag = stg[k-1].flag | q12_sat | q2_sat | q1_sat | a.f | b.f | c.f;
      end
    end else if (k == S_NP) begin : g_np
      always_comb begin
        nxt[k]    = stg[k-1];
        nxt[k].p1 = mul32(magn(stg[k-1].t1), magn(stg[k-1].n1));
        nxt[k].p2 = mul32(magn(stg[k-1].t2), magn(stg[k-1].n2));
      end
    end else if (k == S_NC) begin : g_nc
      always_comb begin
        sat_t b, c;
        nxt[k]      = stg[k-1];
        b           = smulfin(stg[k-1].t1[WORD_BITS-1] ^ stg[k-1].n1[WORD_BITS-1],
                              stg[k-1].p1);
        c           = smulfin(stg[k-1].t2[WORD_BITS-1] ^ stg[k-1].n2[WORD_BITS-1],
                              stg[k-1].p2);
        nxt[k].n1   = b.v;
        nxt[k].n2   = c.v;
        nxt[k].flag = stg[k-1].flag | b.f | c.f;
      end
    end else if (k == S_GP) begin : g_gp
      always_comb begin
        nxt[k]    = stg[k-1];
        nxt[k].p0 = mul32(magn(stg[k-1].n0), magn(gain_x));
        nxt[k].p1 = mul32(magn(stg[k-1].n1), magn(gain_y));
        nxt[k].p2 = mul32(magn(stg[k-1].n2), magn(gain_z));
      end
    end else if (k == S_GC) begin : g_gc
      always_comb begin
        sat_t a, b, c;
        nxt[k]      = stg[k-1];
        a           = smulfin(stg[k-1].n0[WORD_BITS-1] ^ gain_x[WORD_BITS-1], stg[k-1].p0);
        b           = smulfin(stg[k-1].n1[WORD_BITS-1] ^ gain_y[WORD_BITS-1], stg[k-1].p1);
        c           = smulfin(stg[k-1].n2[WORD_BITS-1] ^ gain_z[WORD_BITS-1], stg[k-1].p2);
        nxt[k].n0   = a.v;
        nxt[k].n1   = b.v;
        nxt[k].n2   = c.v;
        nxt[k].flag = stg[k-1].flag | a.f | b.f | c.f;
      end
    end else if (k == S_ABS) begin : g_abs
      // optional abs of y and z (imaginary only), then swap back
      always_comb begin
        sat_t                        b, c;
        logic signed [WORD_BITS-1:0] y, zz;
        logic                        f;
        nxt[k] = stg[k-1];
        b      = sabs(stg[k-1].n1);
        c      = sabs(stg[k-1].n2);
        y      = stg[k-1].n1;
        zz     = stg[k-1].n2;
        f      = stg[k-1].flag;
        if (mode[M_IMAG] && mode[M_ABSY]) begin
          y = b.v;
          f = f | b.f;
        end
        if (mode[M_IMAG] && mode[M_ABSZ]) begin
          zz = c.v;
          f  = f | c.f;
        end
        nxt[k].n1   = y;
        nxt[k].n0   = mode[M_SWAP] ? zz : stg[k-1].n0;
        nxt[k].n2   = mode[M_SWAP] ? stg[k-1].n0 : zz;
        nxt[k].flag = f;
      end
    end else if (k == S_ADD) begin : g_add
      // plain or sign-following add; old point moves into t
      always_comb begin
        sat_t a, b, c;
        nxt[k]    = stg[k-1];
        nxt[k].t0 = stg[k-1].z0;
        nxt[k].t1 = stg[k-1].z1;
        nxt[k].t2 = stg[k-1].z2;
        if (!mode[M_SIGN] || stg[k-1].z0 > 0) begin
          a = sadd(stg[k-1].z0, stg[k-1].n0);
        end else if (stg[k-1].z0 < 0) begin
          a = ssub(stg[k-1].z0, stg[k-1].n0);
        end else begin
          a = '{v: stg[k-1].z0, f: 1'b0};
        end
        if (!mode[M_SIGN] || stg[k-1].z1 > 0) begin
          b = sadd(stg[k-1].z1, stg[k-1].n1);
        end else if (stg[k-1].z1 < 0) begin
          b = ssub(stg[k-1].z1, stg[k-1].n1);
        end else begin
          b = '{v: stg[k-1].z1, f: 1'b0};
        end
        if (!mode[M_SIGN] || stg[k-1].z2 > 0) begin
          c = sadd(stg[k-1].z2, stg[k-1].n2);
        end else if (stg[k-1].z2 < 0) begin
          c = ssub(stg[k-1].z2, stg[k-1].n2);
        end else begin
          c = '{v: stg[k-1].z2, f: 1'b0};
        end
        nxt[k].z0   = a.v;
        nxt[k].z1   = b.v;
        nxt[k].z2   = c.v;
        nxt[k].flag = stg[k-1].flag | a.f | b.f | c.f;
      end
    end else if (k == S_LP) begin : g_lp
      always_comb begin
        nxt[k]    = stg[k-1];
        nxt[k].p0 = mul32(magn(stg[k-1].z0), magn(stg[k-1].z0));
        nxt[k].p1 = mul32(magn(stg[k-1].z1), magn(stg[k-1].z1));
        nxt[k].p2 = mul32(magn(stg[k-1].z2), magn(stg[k-1].z2));
        nxt[k].p3 = mul32(magn(stg[k-1].t0), magn(stg[k-1].t0));
        nxt[k].p4 = mul32(magn(stg[k-1].t1), magn(stg[k-1].t1));
        nxt[k].p5 = mul32(magn(stg[k-1].t2), magn(stg[k-1].t2));
      end
    end else if (k == S_LS) begin : g_ls
      // sums of squares stay below 2^64
      always_comb begin
        nxt[k]    = stg[k-1];
        nxt[k].p0 = stg[k-1].p0 + stg[k-1].p1 + stg[k-1].p2;
        nxt[k].p3 = stg[k-1].p3 + stg[k-1].p4 + stg[k-1].p5;
      end
    end else if (k == S_R1) begin : g_r1
      always_comb begin
        nxt[k]         = stg[k-1];
        nxt[k].p0      = mul32(magn(stg[k-1].de), ratio);
        nxt[k].de_flag = stg[k-1].de_flag | ratio_sat;
      end
    end else if (k == S_R2) begin : g_r2
      always_comb begin
        sat_t a;
        nxt[k]         = stg[k-1];
        a              = smulfin(stg[k-1].de[WORD_BITS-1], stg[k-1].p0);
        nxt[k].n0      = a.v;
        nxt[k].de_flag = stg[k-1].de_flag | a.f;
      end
    end else if (k == S_R3) begin : g_r3
      always_comb begin
        nxt[k]    = stg[k-1];
        nxt[k].p0 = mul32(magn(stg[k-1].n0), magn(de_scale));
      end
    end else if (k == S_R4) begin : g_r4
      always_comb begin
        sat_t a;
        nxt[k]         = stg[k-1];
        a              = smulfin(stg[k-1].n0[WORD_BITS-1] ^ de_scale[WORD_BITS-1],
                                 stg[k-1].p0);
        nxt[k].n0      = a.v;
        nxt[k].de_flag = stg[k-1].de_flag | a.f;
      end
    end else if (k == S_R5) begin : g_r5
      // estimate update only when enabled, its clamps count only then
      always_comb begin
        sat_t a;
        nxt[k] = stg[k-1];
        a      = sadd(stg[k-1].n0, de_offset);
        if (mode[M_DE]) begin
          nxt[k].de   = a.v;
          nxt[k].flag = stg[k-1].flag | stg[k-1].de_flag | a.f;
        end
      end
    end else begin : g_pass
      // alignment with the divider and square root units
      always_comb begin
        nxt[k] = stg[k-1];
      end
    end
  end

  // output register plus skid register
  res_t res_last, out_q, skid_q;
  logic push;

  assign push          = en && vld[N_STG-1];
  assign res_last.z0   = stg[N_STG-1].z0;
  assign res_last.z1   = stg[N_STG-1].z1;
  assign res_last.z2   = stg[N_STG-1].z2;
  assign res_last.de   = stg[N_STG-1].de;
  assign res_last.flag = stg[N_STG-1].flag;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_ready) begin
      out_q <= skid_valid ? skid_q : res_last;
    end else if (push) begin
      skid_q <= res_last;
    end
  end

  assign out_z_x   = out_q.z0;
  assign out_z_y   = out_q.z1;
  assign out_z_z   = out_q.z2;
  assign de_out    = out_q.de;
  assign saturated = out_q.flag;

endmodule

// ===== design/scas_div.sv =====
// pipelined fixed-point divider, one quotient bit per stage, saturating
module scas_div import scas_pkg::*; (
  input  logic                        clk,
  input  logic                        en,
  input  logic [WORD_BITS-1:0]        num,
  input  logic [WORD_BITS-1:0]        den,
  input  logic                        neg,
  output logic signed [WORD_BITS-1:0] q,
  output logic                        sat
);

  typedef struct packed {
    logic [REM_BITS-1:0]  rem;
    logic [QBITS-1:0]     quo;
    logic [WORD_BITS-1:0] den;
    logic                 neg;
    logic                 ovf;
  } dst_t;

  dst_t st     [QBITS];
  dst_t st_nxt [QBITS];
  sat_t fin;

  for (genvar k = 0; k < QBITS; k++) begin : g_bit
    dst_t        cur;
    logic [63:0] trial;
    if (k == 0) begin : g_first
      always_comb begin
        cur.rem = {num, {FRAC_BITS{1'b0}}};
        cur.quo = '0;
        cur.den = den;
        cur.neg = neg;
        // quotient needs more than QBITS bits (also catches a zero divisor)
        cur.ovf = {{(64-REM_BITS){1'b0}}, num, {FRAC_BITS{1'b0}}} >= {den, 32'd0};
      end
    end else begin : g_next
      always_comb begin
        cur = st[k-1];
      end
    end
    always_comb begin
      trial = 64'(cur.den) << (QBITS - 1 - k);
    end
    always_comb begin
      st_nxt[k] = cur;
      if ({{(64-REM_BITS){1'b0}}, cur.rem} >= trial) begin
        st_nxt[k].rem = cur.rem - trial[REM_BITS-1:0];
        st_nxt[k].quo[QBITS-1-k] = 1'b1;
      end
    end
  end

  always_comb begin
    fin = clampw(st[QBITS-1].neg,
                 st[QBITS-1].ovf ? {MAG_BITS{1'b1}} : MAG_BITS'(st[QBITS-1].quo));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < QBITS; k++) begin
        st[k] <= st_nxt[k];
      end
      q   <= fin.v;
      sat <= fin.f;
    end
  end

endmodule

// ===== design/scas_sqrt.sv =====
// pipelined integer square root of a 64-bit sum, one root bit per stage
module scas_sqrt import scas_pkg::*; (
  input  logic             clk,
  input  logic             en,
  input  logic [63:0]      s,
  output logic [QBITS-1:0] r
);

  typedef struct packed {
    logic [63:0]      rem;
    logic [QBITS-1:0] root;
  } sst_t;

  sst_t st     [QBITS];
  sst_t st_nxt [QBITS];

  for (genvar k = 0; k < QBITS; k++) begin : g_bit
    sst_t        cur;
    logic [64:0] test;
    if (k == 0) begin : g_first
      always_comb begin
        cur.rem  = s;
        cur.root = '0;
      end
    end else begin : g_next
      always_comb begin
        cur = st[k-1];
      end
    end
    // (2r + 2^i) * 2^i
    always_comb begin
      test = (65'(cur.root) << (QBITS - k)) + (65'd1 << (2 * (QBITS - 1 - k)));
    end
    always_comb begin
      st_nxt[k] = cur;
      if ({1'b0, cur.rem} >= test) begin
        st_nxt[k].rem = cur.rem - test[63:0];
        st_nxt[k].root[QBITS-1-k] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < QBITS; k++) begin
        st[k] <= st_nxt[k];
      end
    end
  end

  assign r = st[QBITS-1].root;

endmodule

// ===== design/scas_checker.sv =====
// port-level checks for the scator step, bound to the top level
`include "scator_constant_add_step_core_macros.svh"

module scas_checker import scas_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic [4:0]  paddr,
  input logic [31:0] prdata,
  input logic        pready,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_z_x,
  input logic [31:0] de_out,
  input logic        saturated
);

  // with no result shown the skid register is empty, so requests flow
  `SCAS_ASSERT_IMP(a_idle_ready, clk, rst, !out_valid, in_ready)

  // a held result keeps its payload
  `SCAS_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_z_x) && $stable(de_out) && $stable(saturated))

  `SCAS_ASSERT_IMP(a_pready, clk, rst, 1'b1, pready)

  // mode register reads back only its seven bits
  `SCAS_ASSERT_IMP(a_mode_rd, clk, rst, paddr[4:2] == REG_MODE, prdata[31:7] == 25'd0)

endmodule

bind scator_constant_add_step_core scas_checker u_scas_checker (.*);

// ===== verif/tb.sv =====
// self-checking testbench for the scator constant-add step core
module tb;
  import scas_pkg::*;

  // point, pixel constant and distance estimate of one request
  typedef struct {
    logic signed [31:0] zx, zy, zz, cx, cy, cz, de;
  } step_req_t;

  // new point, new estimate and clamp flag of one result
  typedef struct {
    logic signed [31:0] zx, zy, zz, de;
    logic               sat;
  } step_res_t;

  typedef struct {
    step_req_t r;
    bit        typed;
    step_res_t e;
  } dir_row_t;

  localparam longint W_MAX = 64'sd2147483647;
  localparam longint W_MIN = -64'sd2147483648;
  localparam longint F_ONE = 64'sd1 << 20;
  localparam logic [31:0] Q_ONE = 32'h0010_0000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [31:0] in_z_x = '0, in_z_y = '0, in_z_z = '0;
  logic signed [31:0] in_c_x = '0, in_c_y = '0, in_c_z = '0, de_in = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] out_z_x, out_z_y, out_z_z, de_out;
  logic saturated;

  // shadow copy of the configuration registers
  logic [6:0]         mode_q = '0;
  longint             small_q = 0;
  longint             gain_xq = F_ONE, gain_yq = F_ONE, gain_zq = F_ONE;
  longint             de_scale_q = F_ONE, de_offset_q = 0;

  bit                 clamp_hit;
  step_res_t          pending_res[$];
  int                 mismatches = 0;
  int                 orphans = 0;
  int                 rx_cnt = 0;
  int                 rx_style = 0;
  int                 burst_left = 0;
  bit                 gaps_on = 1'b1;
  dir_row_t           dir_tbl[$];

  always #2 clk = ~clk;

  scator_constant_add_step_core DUT (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid, .in_ready, .in_z_x, .in_z_y, .in_z_z, .in_c_x, .in_c_y, .in_c_z,
    .de_in, .out_valid, .out_ready, .out_z_x, .out_z_y, .out_z_z, .de_out,
    .saturated
  );

  // ---------------------------------------------------------------------
  // fixed-point predictor, Q12.20 in a 32-bit word, saturating everywhere
  // ---------------------------------------------------------------------

  function automatic logic [127:0] mag_of(input longint a);
    return (a < 0) ? 128'(-a) : 128'(a);
  endfunction

  // clamp a sign and magnitude to the word, noting any clamp
  function automatic longint fit_word(input bit neg, input logic [127:0] mag);
    if (!neg) begin
      if (mag > 128'(W_MAX)) begin
        clamp_hit = 1'b1;
        return W_MAX;
      end
      return longint'(mag[63:0]);
    end
    if (mag > 128'(W_MAX) + 1) begin
      clamp_hit = 1'b1;
      return W_MIN;
    end
    return -longint'(mag[63:0]);
  endfunction

  function automatic longint q_add(input longint a, input longint b);
    longint s;
    s = a + b;
    return fit_word(s < 0, mag_of(s));
  endfunction

  function automatic longint q_sub(input longint a, input longint b);
    longint s;
    s = a - b;
    return fit_word(s < 0, mag_of(s));
  endfunction

  function automatic longint q_abs(input longint a);
    return fit_word(1'b0, mag_of(a));
  endfunction

  // product truncated toward zero
  function automatic longint q_mul(input longint a, input longint b);
    logic [127:0] p;
    p = mag_of(a) * mag_of(b);
    return fit_word((a < 0) != (b < 0), p >> 20);
  endfunction

  // quotient truncated toward zero, divide by zero saturates by numerator sign
  function automatic longint q_div(input longint a, input longint b);
    if (b == 0) begin
      clamp_hit = 1'b1;
      return (a < 0) ? W_MIN : W_MAX;
    end
    return fit_word((a < 0) != (b < 0), (mag_of(a) << 20) / mag_of(b));
  endfunction

  // floor of the euclidean length, raw units
  function automatic logic [127:0] vec_len(input longint a, input longint b,
                                           input longint c);
    logic [127:0] s, r, t;
    s = mag_of(a) * mag_of(a) + mag_of(b) * mag_of(b) + mag_of(c) * mag_of(c);
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      t = r | (128'd1 << i);
      if (t * t <= s) r = t;
    end
    return r;
  endfunction

  function automatic step_res_t predict_step(input step_req_t q);
    longint z[3], oz[3], t[3], cc[3], n[3], g[3], tmp, de, ratio;
    logic [127:0] nl, ol;
    bit imag;
    step_res_t res;
    clamp_hit = 1'b0;
    imag = mode_q[M_IMAG];
    z[0] = q.zx; z[1] = q.zy; z[2] = q.zz;
    t[0] = q.cx; t[1] = q.cy; t[2] = q.cz;
    oz = z;
    de = q.de;
    if (mode_q[M_SWAP]) begin
      tmp = t[0]; t[0] = t[2]; t[2] = tmp;
    end
    for (int i = 0; i < 3; i++)
      cc[i] = mode_q[M_ABS] ? q_abs(t[i]) : q_mul(t[i], t[i]);
    // reciprocal rule for a small x term
    if (cc[0] < small_q) cc[0] = q_sub(q_div(F_ONE, cc[0]), F_ONE);
    n[0] = q_add(t[0], q_div(q_mul(cc[1], cc[2]), cc[0]));
    if (imag) begin
      n[1] = q_mul(t[1], q_sub(F_ONE, q_div(cc[2], cc[0])));
      n[2] = q_mul(t[2], q_sub(F_ONE, q_div(cc[1], cc[0])));
    end else begin
      n[1] = q_mul(t[1], q_add(F_ONE, q_div(cc[2], cc[0])));
      n[2] = q_mul(t[2], q_add(F_ONE, q_div(cc[1], cc[0])));
    end
    g[0] = gain_xq; g[1] = gain_yq; g[2] = gain_zq;
    for (int i = 0; i < 3; i++) n[i] = q_mul(n[i], g[i]);
    if (imag && mode_q[M_ABSY]) n[1] = q_abs(n[1]);
    if (imag && mode_q[M_ABSZ]) n[2] = q_abs(n[2]);
    if (mode_q[M_SWAP]) begin
      tmp = n[0]; n[0] = n[2]; n[2] = tmp;
    end
    // plain or sign-following add, a zero axis stays put in the latter
    for (int i = 0; i < 3; i++) begin
      if (!mode_q[M_SIGN]) z[i] = q_add(z[i], n[i]);
      else if (z[i] > 0) z[i] = q_add(z[i], n[i]);
      else if (z[i] < 0) z[i] = q_sub(z[i], n[i]);
    end
    if (mode_q[M_DE]) begin
      nl = vec_len(z[0], z[1], z[2]);
      ol = vec_len(oz[0], oz[1], oz[2]);
      if (ol == 0) begin
        clamp_hit = 1'b1;
        ratio = W_MAX;
      end else begin
        ratio = fit_word(1'b0, (nl << 20) / ol);
      end
      de = q_add(q_mul(q_mul(de, ratio), de_scale_q), de_offset_q);
    end
    res.zx = 32'(z[0]); res.zy = 32'(z[1]); res.zz = 32'(z[2]);
    res.de = 32'(de);
    res.sat = clamp_hit;
    return res;
  endfunction

  // ---------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------

  task automatic reg_write(input reg_idx_t idx, input logic [31:0] val);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= 5'(idx) << 2; pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_MODE:      mode_q = val[6:0];
      REG_SMALL:     small_q = longint'(val[30:0]);
      REG_GAIN_X:    gain_xq = longint'($signed(val));
      REG_GAIN_Y:    gain_yq = longint'($signed(val));
      REG_GAIN_Z:    gain_zq = longint'($signed(val));
      REG_DE_SCALE:  de_scale_q = longint'($signed(val));
      REG_DE_OFFSET: de_offset_q = longint'($signed(val));
      default: ;
    endcase
  endtask

  task automatic load_config(input logic [6:0] mode, input logic [31:0] small_lim,
                             input logic [31:0] gx, input logic [31:0] gy,
                             input logic [31:0] gz, input logic [31:0] ds,
                             input logic [31:0] dofs);
    reg_write(REG_MODE, 32'(mode));
    reg_write(REG_SMALL, small_lim);
    reg_write(REG_GAIN_X, gx);
    reg_write(REG_GAIN_Y, gy);
    reg_write(REG_GAIN_Z, gz);
    reg_write(REG_DE_SCALE, ds);
    reg_write(REG_DE_OFFSET, dofs);
  endtask

  // sends one request in bursts; valid stays up across back-to-back requests
  task automatic send_req(input step_req_t q, input bit typed, input step_res_t e);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if (gaps_on) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_z_x <= q.zx; in_z_y <= q.zy; in_z_z <= q.zz;
    in_c_x <= q.cx; in_c_y <= q.cy; in_c_z <= q.cz; de_in <= q.de;
    do @(posedge clk); while (!in_ready);
    pending_res.push_back(typed ? e : predict_step(q));
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (pending_res.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // mostly modest magnitudes so the datapath does not just saturate
  function automatic logic [31:0] pick_word;
    case ($urandom_range(0, 7))
      0:       return $urandom();
      1:       return 32'($signed($urandom_range(0, 2 ** 24)) - 2 ** 23);
      2:       return 32'($signed($urandom_range(0, 2 ** 21)) - 2 ** 20);
      3:       return 32'($signed($urandom_range(0, 2 ** 18)) - 2 ** 17);
      4:       return '0;
      5:       return $urandom_range(0, 1) ? Q_ONE : -Q_ONE;
      6:       return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return 32'($signed($urandom_range(0, 2 ** 27)) - 2 ** 26);
    endcase
  endfunction

  function automatic step_req_t pick_req;
    step_req_t q;
    q.zx = pick_word(); q.zy = pick_word(); q.zz = pick_word();
    q.cx = pick_word(); q.cy = pick_word(); q.cz = pick_word();
    q.de = pick_word();
    // an all-zero point now and then to hit the zero old length
    if ($urandom_range(0, 15) == 0) begin
      q.zx = '0; q.zy = '0; q.zz = '0;
    end
    return q;
  endfunction

  function automatic dir_row_t row(input logic [31:0] zx, zy, zz, cx, cy, cz, de);
    dir_row_t d;
    d.r.zx = zx; d.r.zy = zy; d.r.zz = zz;
    d.r.cx = cx; d.r.cy = cy; d.r.cz = cz; d.r.de = de;
    d.typed = 1'b0;
    d.e = '{default: '0};
    return d;
  endfunction

  // ---------------------------------------------------------------------
  // result side: stall pattern and comparison against the oldest prediction
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    step_res_t e;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (pending_res.size() == 0) begin
          orphans++;
          if (orphans + mismatches <= 10)
            $display("unexpected result z=(%h %h %h) de=%h sat=%b",
                     out_z_x, out_z_y, out_z_z, de_out, saturated);
        end else begin
          e = pending_res.pop_front();
          if (e.zx !== out_z_x || e.zy !== out_z_y || e.zz !== out_z_z ||
              e.de !== de_out || e.sat !== saturated) begin
            mismatches++;
            if (orphans + mismatches <= 10)
              $display("mismatch exp z=(%h %h %h) de=%h sat=%b got z=(%h %h %h) de=%h sat=%b",
                       e.zx, e.zy, e.zz, e.de, e.sat,
                       out_z_x, out_z_y, out_z_z, de_out, saturated);
          end
        end
      end
      // stall style redrawn at random, one of them never stalls
      rx_cnt <= rx_cnt + 1;
      if (rx_cnt % 256 == 0) rx_style <= $urandom_range(0, 3);
      case (rx_style)
        0:       out_ready <= 1'b1;
        1:       out_ready <= ($urandom_range(0, 3) != 0);
        2:       out_ready <= ((rx_cnt % 7) < 3);
        default: out_ready <= ($urandom_range(0, 9) == 0);
      endcase
    end
  end

  // watchdog
  initial begin
    #4000000;
    $display("** scator_constant_add_step_core: FAILED **");
    $finish;
  end

  initial begin
    step_req_t q;
    step_res_t none;
    dir_row_t d;
    none = '{default: '0};

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed rows under the reset configuration
    // all zero: 0/0 divides saturate high, x term runs to the word max
    d = row('0, '0, '0, '0, '0, '0, '0);
    d.typed = 1'b1;
    d.e = '{zx: 32'h7FFF_FFFF, zy: '0, zz: '0, de: '0, sat: 1'b1};
    dir_tbl.push_back(d);
    // unit constant: every term comes out as 2.0, nothing clamps
    d = row('0, '0, '0, Q_ONE, Q_ONE, Q_ONE, Q_ONE);
    d.typed = 1'b1;
    d.e = '{zx: 32'h0020_0000, zy: 32'h0020_0000, zz: 32'h0020_0000,
            de: Q_ONE, sat: 1'b0};
    dir_tbl.push_back(d);
    dir_tbl.push_back(row('1, '1, '1, '1, '1, '1, '1));
    dir_tbl.push_back(row(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                          32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    dir_tbl.push_back(row(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                          32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    dir_tbl.push_back(row(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
                          32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555));
    dir_tbl.push_back(row(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
                          32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA));
    dir_tbl.push_back(row(Q_ONE, -Q_ONE, '0, -Q_ONE, Q_ONE, 32'h0008_0000, Q_ONE));
    dir_tbl.push_back(row(-Q_ONE, Q_ONE, 32'h0030_0000, 32'h0000_0400, -Q_ONE,
                          32'h0020_0000, 32'h0002_0000));
    dir_tbl.push_back(row(32'h0010_0001, '0, -32'h0000_0001, 32'h0000_0001,
                          32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000));
    foreach (dir_tbl[i]) send_req(dir_tbl[i].r, dir_tbl[i].typed, dir_tbl[i].e);
    drain();

    // settings: four fixed ones first (extremes among them), then random ones
    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0: load_config(7'h7F, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                       32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        1: load_config(7'h00, 32'h0000_0000, '0, '0, '0, '0, 32'h8000_0000);
        2: load_config(7'h74, 32'h0008_0000, Q_ONE, -Q_ONE, 32'h0008_0000,
                       Q_ONE, '0);
        3: load_config(7'h4B, 32'h0000_1000, 32'h0018_0000, Q_ONE, -Q_ONE,
                       32'h0002_0000, Q_ONE);
        default:
          load_config(7'($urandom_range(0, 127)),
                      $urandom_range(0, 1) ? 32'($urandom_range(0, 2 ** 21))
                                           : ($urandom() >> 1),
                      pick_word(), pick_word(), pick_word(), pick_word(),
                      pick_word());
      endcase
      gaps_on = (ph % 3 != 2);
      repeat (184) begin
        q = pick_req();
        send_req(q, 1'b0, none);
      end
      drain();
    end

    repeat (200) @(posedge clk);
    if (mismatches == 0 && orphans == 0 && pending_res.size() == 0)
      $display("** scator_constant_add_step_core: PASSED **");
    else
      $display("** scator_constant_add_step_core: FAILED **");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+design
design/scas_pkg.sv
design/scas_div.sv
design/scas_sqrt.sv
design/scator_constant_add_step_core.sv
design/scas_checker.sv
verif/tb.sv
